// ===== rtl/core/rcpc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcpc_pkg
// Shared types and constants of the rc pulse capture and failsafe block.
// ----------------------------------------------------------------------------
package rcpc_pkg;

	localparam int LINE_COUNT = 5;
	localparam int LINE_W     = 3;
	localparam int TS_W       = 16;
	localparam int REG_W      = 16;
	localparam int REG_IDX_W  = 3;

	// receiver line codes
	localparam logic [LINE_W-1:0] LINE_KILL   = 3'd0;
	localparam logic [LINE_W-1:0] LINE_THRUST = 3'd3;

	// configuration register indexes
	localparam logic [REG_IDX_W-1:0] REG_KILL_THRESHOLD  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_SAFE_COMPARE    = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_MIN_COMPARE     = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_MAX_COMPARE     = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_THROTTLE_OFFSET = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_THROTTLE_GAIN   = 3'd5;

	// register reset values
	localparam logic [REG_W-1:0] RST_KILL_THRESHOLD  = 16'd1250;
	localparam logic [REG_W-1:0] RST_SAFE_COMPARE    = 16'd1750;
	localparam logic [REG_W-1:0] RST_MIN_COMPARE     = 16'd1800;
	localparam logic [REG_W-1:0] RST_MAX_COMPARE     = 16'd3600;
	localparam logic [REG_W-1:0] RST_THROTTLE_OFFSET = 16'd10;
	localparam logic [REG_W-1:0] RST_THROTTLE_GAIN   = 16'd1800;

	// divide by 1000 as a shift by 3 and an exact reciprocal multiply for 125
	localparam int PROD_W     = 2 * REG_W;
	localparam int PRE_SHIFT  = 3;
	localparam int DIVIN_W    = PROD_W - PRE_SHIFT;
	localparam int RECIP_W    = 30;
	localparam logic [RECIP_W-1:0] RECIP_125 = 30'd549755814;
	localparam int POST_SHIFT = 36;
	localparam int MUL2_W     = DIVIN_W + RECIP_W;
	localparam int QUOT_W     = MUL2_W - POST_SHIFT;

	typedef enum logic [1:0] {
		UPD_NONE,
		UPD_THRUST,
		UPD_KILL
	} upd_t;

	typedef struct packed {
		logic [LINE_W-1:0] channel;
		logic              level;
		logic [TS_W-1:0]   timestamp;
	} evt_t;

	typedef struct packed {
		logic [LINE_W-1:0] source_line;
		logic [TS_W-1:0]   pulse_width;
		logic              width_valid;
		logic              kill_active;
		logic [REG_W-1:0]  motor_compare;
	} res_t;

	// per-beat capture result carried down the pipeline
	typedef struct packed {
		logic [LINE_W-1:0] source_line;
		logic [TS_W-1:0]   pulse_width;
		logic              width_valid;
		logic              kill_active;
		upd_t              upd;
	} cap_t;

endpackage

// ===== rtl/core/rcpc_capture.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcpc_capture
// Per-line rise time store, pulse width measure and kill latch.
// ----------------------------------------------------------------------------
module rcpc_capture (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       advance,
	input  rcpc_pkg::evt_t             evt,
	input  logic [rcpc_pkg::REG_W-1:0] kill_threshold,
	output rcpc_pkg::cap_t             cap
);

	logic [rcpc_pkg::TS_W-1:0] rise_time_q [rcpc_pkg::LINE_COUNT];
	logic                      kill_q;

	logic                        line_ok;
	logic                        act;
	logic                        falling;
	logic                        kill_hit;
	logic [rcpc_pkg::LINE_W-1:0] idx;
	logic [rcpc_pkg::TS_W-1:0]   width;

	always_comb begin
		line_ok  = evt.channel < rcpc_pkg::LINE_W'(rcpc_pkg::LINE_COUNT);
		act      = !kill_q && line_ok;
		idx      = line_ok ? evt.channel : '0;
		// modulo timer wrap falls out of the narrow subtract
		width    = evt.timestamp - rise_time_q[idx];
		falling  = act && !evt.level;
		kill_hit = falling && (evt.channel == rcpc_pkg::LINE_KILL) && (width > kill_threshold);

		cap.source_line = evt.channel;
		cap.pulse_width = falling ? width : '0;
		cap.width_valid = falling;
		cap.kill_active = kill_q || kill_hit;
		if (kill_hit) begin
			cap.upd = rcpc_pkg::UPD_KILL;
		end else if (falling && (evt.channel == rcpc_pkg::LINE_THRUST)) begin
			cap.upd = rcpc_pkg::UPD_THRUST;
		end else begin
			cap.upd = rcpc_pkg::UPD_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < rcpc_pkg::LINE_COUNT; i++) begin
				rise_time_q[i] <= '0;
			end
			kill_q <= 1'b0;
		end else if (advance) begin
			if (act && evt.level) begin
				rise_time_q[idx] <= evt.timestamp;
			end
			if (kill_hit) begin
				kill_q <= 1'b1;
			end
		end
	end

endmodule

// ===== rtl/core/rc_pulse_capture_failsafe.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc_pulse_capture_failsafe
// Receiver pwm pulse width capture with kill failsafe and thrust mapping.
// ----------------------------------------------------------------------------
// path: an accepted event beat passes stage 1, stages 2 to 4 and the result register
// throughput: one event beat per cycle while res_stall is low, set by the five-stage
//   pipeline with the two multipliers (gain, then reciprocal of 125) on separate stages
// reset: arst_n clears config to defaults, rise times, kill latch, motor
//   compare and all stage valids; no clearing pass, ready right after reset
// ----------------------------------------------------------------------------
module rc_pulse_capture_failsafe (
	input  logic                           clk,
	input  logic                           arst_n,
	// event channel
	input  logic                           evt_valid,
	output logic                           evt_stall,
	input  rcpc_pkg::evt_t                 evt,
	// result channel
	output logic                           res_valid,
	input  logic                           res_stall,
	output rcpc_pkg::res_t                 res,
	// config write port
	input  logic                           cfg_we,
	input  logic [rcpc_pkg::REG_IDX_W-1:0] cfg_index,
	input  logic [rcpc_pkg::REG_W-1:0]     cfg_data
);

	// ------------------------------------------------------------------
	// config registers
	// ------------------------------------------------------------------
	logic [rcpc_pkg::REG_W-1:0] kill_threshold_q;
	logic [rcpc_pkg::REG_W-1:0] safe_compare_q;
	logic [rcpc_pkg::REG_W-1:0] min_compare_q;
	logic [rcpc_pkg::REG_W-1:0] max_compare_q;
	logic [rcpc_pkg::REG_W-1:0] throttle_offset_q;
	logic [rcpc_pkg::REG_W-1:0] throttle_gain_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kill_threshold_q  <= rcpc_pkg::RST_KILL_THRESHOLD;
			safe_compare_q    <= rcpc_pkg::RST_SAFE_COMPARE;
			min_compare_q     <= rcpc_pkg::RST_MIN_COMPARE;
			max_compare_q     <= rcpc_pkg::RST_MAX_COMPARE;
			throttle_offset_q <= rcpc_pkg::RST_THROTTLE_OFFSET;
			throttle_gain_q   <= rcpc_pkg::RST_THROTTLE_GAIN;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rcpc_pkg::REG_KILL_THRESHOLD:  kill_threshold_q  <= cfg_data;
				rcpc_pkg::REG_SAFE_COMPARE:    safe_compare_q    <= cfg_data;
				rcpc_pkg::REG_MIN_COMPARE:     min_compare_q     <= cfg_data;
				rcpc_pkg::REG_MAX_COMPARE:     max_compare_q     <= cfg_data;
				rcpc_pkg::REG_THROTTLE_OFFSET: throttle_offset_q <= cfg_data;
				rcpc_pkg::REG_THROTTLE_GAIN:   throttle_gain_q   <= cfg_data;
				default: ; // writes beyond the register list are dropped
			endcase
		end
	end

	// ------------------------------------------------------------------
	// pipeline flow control: each stage moves when the next one is free
	// ------------------------------------------------------------------
	logic v_s1, v_s2, v_s3, v_s4, v_out_q;
	logic mv1, mv2, mv3, mv4;
	logic free1, free2, free3, free4, out_free;
	logic accept;

	always_comb begin
		out_free = !v_out_q || !res_stall;
		mv4      = v_s4 && out_free;
		free4    = !v_s4 || mv4;
		mv3      = v_s3 && free4;
		free3    = !v_s3 || mv3;
		mv2      = v_s2 && free3;
		free2    = !v_s2 || mv2;
		mv1      = v_s1 && free2;
		free1    = !v_s1 || mv1;
		accept   = evt_valid && free1;
	end

	assign evt_stall = !free1;
	assign res_valid = v_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			v_out_q <= 1'b0;
		end else begin
			v_s1    <= accept || (v_s1 && !mv1);
			v_s2    <= mv1 || (v_s2 && !mv2);
			v_s3    <= mv2 || (v_s3 && !mv3);
			v_s4    <= mv3 || (v_s4 && !mv4);
			v_out_q <= mv4 || (v_out_q && res_stall);
		end
	end

	// ------------------------------------------------------------------
	// stage 1: event input register
	// ------------------------------------------------------------------
	rcpc_pkg::evt_t evt_s1;

	always_ff @(posedge clk) begin
		if (accept) begin
			evt_s1 <= evt;
		end
	end

	// ------------------------------------------------------------------
	// capture: rise time store, width and kill latch; state moves with
	// the beat leaving stage 1 so the next beat sees it at once
	// ------------------------------------------------------------------
	rcpc_pkg::cap_t cap;

	rcpc_capture u_capture (
		.clk            (clk),
		.arst_n         (arst_n),
		.advance        (mv1),
		.evt            (evt_s1),
		.kill_threshold (kill_threshold_q),
		.cap            (cap)
	);

	// thrust width minus offset, saturating at zero
	logic [rcpc_pkg::REG_W-1:0] diff;

	always_comb begin
		diff = (cap.pulse_width > throttle_offset_q) ? (cap.pulse_width - throttle_offset_q) : '0;
	end

	// ------------------------------------------------------------------
	// stage 2: capture result and offset difference
	// ------------------------------------------------------------------
	rcpc_pkg::cap_t             cap_s2;
	logic [rcpc_pkg::REG_W-1:0] diff_s2;

	always_ff @(posedge clk) begin
		if (mv1) begin
			cap_s2  <= cap;
			diff_s2 <= diff;
		end
	end

	// ------------------------------------------------------------------
	// stage 3: gain product
	// ------------------------------------------------------------------
	rcpc_pkg::cap_t              cap_s3;
	logic [rcpc_pkg::PROD_W-1:0] prod_s3;

	always_ff @(posedge clk) begin
		if (mv2) begin
			cap_s3  <= cap_s2;
			prod_s3 <= rcpc_pkg::PROD_W'(diff_s2) * rcpc_pkg::PROD_W'(throttle_gain_q);
		end
	end

	// ------------------------------------------------------------------
	// stage 4: product / 1000 as (product >> 3) / 125 via reciprocal
	// ------------------------------------------------------------------
	logic [rcpc_pkg::DIVIN_W-1:0] div_in;
	logic [rcpc_pkg::MUL2_W-1:0]  recip_prod;

	always_comb begin
		div_in     = prod_s3[rcpc_pkg::PROD_W-1:rcpc_pkg::PRE_SHIFT];
		recip_prod = rcpc_pkg::MUL2_W'(div_in) * rcpc_pkg::MUL2_W'(rcpc_pkg::RECIP_125);
	end

	rcpc_pkg::cap_t              cap_s4;
	logic [rcpc_pkg::QUOT_W-1:0] quot_s4;

	always_ff @(posedge clk) begin
		if (mv3) begin
			cap_s4  <= cap_s3;
			quot_s4 <= recip_prod[rcpc_pkg::MUL2_W-1:rcpc_pkg::POST_SHIFT];
		end
	end

	// ------------------------------------------------------------------
	// clamp and motor compare update, applied in beat order
	// ------------------------------------------------------------------
	logic [rcpc_pkg::REG_W-1:0] motor_level_q;
	logic [rcpc_pkg::REG_W-1:0] clamped;
	logic [rcpc_pkg::REG_W-1:0] motor_next;

	always_comb begin
		// when min is set above max, a value above max takes max and any other takes min
		if (quot_s4 > rcpc_pkg::QUOT_W'(max_compare_q)) begin
			clamped = max_compare_q;
		end else if (quot_s4 < rcpc_pkg::QUOT_W'(min_compare_q)) begin
			clamped = min_compare_q;
		end else begin
			clamped = quot_s4[rcpc_pkg::REG_W-1:0];
		end
		case (cap_s4.upd)
			rcpc_pkg::UPD_THRUST: motor_next = clamped;
			rcpc_pkg::UPD_KILL:   motor_next = safe_compare_q;
			default:              motor_next = motor_level_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			motor_level_q <= '0;
		end else if (mv4) begin
			motor_level_q <= motor_next;
		end
	end

	// ------------------------------------------------------------------
	// result register
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (mv4) begin
			res.source_line   <= cap_s4.source_line;
			res.pulse_width   <= cap_s4.pulse_width;
			res.width_valid   <= cap_s4.width_valid;
			res.kill_active   <= cap_s4.kill_active;
			res.motor_compare <= motor_next;
		end
	end

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
	// once latched, failsafe stays latched for every later beat
	a_kill_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		mv1 && cap.kill_active |=> cap.kill_active)
		else $error("kill latch released");

	// a beat without a measured width carries a zero width
	a_width_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.width_valid |-> res.pulse_width == '0)
		else $error("width reported on a beat without width");

	// the motor compare only changes when a beat reaches the result stage
	a_motor_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!mv4 |=> $stable(motor_level_q))
		else $error("motor compare changed without a beat");

endmodule
